FILE: rtl/dld_pkg.sv
// shared types and constants for the decimal length deframer
`default_nettype none
package dld_pkg;

   localparam int BYTE_W       = 8;
   localparam int OPC_W        = 24;
   localparam int LEN_W        = 34;
   localparam int WEIGHT_W     = LEN_W + 4;
   localparam int OPCODE_CHARS = 3;

   localparam logic [LEN_W-1:0]  LEN_MAX   = {LEN_W{1'b1}};
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic              header_valid;
      logic [OPC_W-1:0]  opcode_chars;
      logic [LEN_W-1:0]  frame_length;
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic              last_of_frame;
   } rsp_item_type;

endpackage
`default_nettype wire

FILE: rtl/decimal_length_deframer_top.sv
// top level of the decimal length deframer
// Takes one stream byte per cycle on req_ while req_stall is low and gives at most
// one result per byte on rsp_: a header result after the last of the 3 + LENGTH_DIGITS
// header bytes, then one result per payload byte. Results pass through a two-entry queue
// and an output register, so req_stall rises only once two results are waiting behind a
// stalled output. No start-up delay after reset.
`default_nettype none
module decimal_length_deframer_top
   import dld_pkg::*;
#(
   parameter int LENGTH_DIGITS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_header_valid,
   output logic [OPC_W-1:0]       rsp_opcode_chars,
   output logic [LEN_W-1:0]       rsp_frame_length,
   output logic                   rsp_payload_valid,
   output logic [BYTE_W-1:0]      rsp_payload_byte,
   output logic                   rsp_last_of_frame
);

   logic         accept;
   logic         push;
   rsp_item_type push_item;
   logic         pop;
   logic         full;
   logic         empty;
   rsp_item_type head_item;
   rsp_item_type rsp_item;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   dld_front #(
      .LENGTH_DIGITS (LENGTH_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .push      (push),
      .push_item (push_item)
   );

   dld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head_item (head_item)
   );

   dld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head_item (head_item),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_header_valid  = rsp_item.header_valid;
   assign rsp_opcode_chars  = rsp_item.opcode_chars;
   assign rsp_frame_length  = rsp_item.frame_length;
   assign rsp_payload_valid = rsp_item.payload_valid;
   assign rsp_payload_byte  = rsp_item.payload_byte;
   assign rsp_last_of_frame = rsp_item.last_of_frame;

endmodule
`default_nettype wire

FILE: rtl/dld_front.sv
// front end: header parsing, length decode and payload counting
`default_nettype none
module dld_front
   import dld_pkg::*;
#(
   parameter int LENGTH_DIGITS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output logic                   push,
   output rsp_item_type           push_item
);

   localparam int HDR_BYTES = OPCODE_CHARS + LENGTH_DIGITS;
   localparam int POS_W     = $clog2(HDR_BYTES + 1);

   logic                in_payload_ff, in_payload_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [OPC_W-1:0]    opcode_ff, opcode_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                ended_ff, ended_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;

   logic [BYTE_W-1:0]   digit_raw;
   logic [3:0]          digit;
   logic                is_digit;
   logic [WEIGHT_W+3:0] product;
   logic [WEIGHT_W+4:0] sum;
   logic [POS_W-1:0]    pos_next;

   assign digit_raw = rx_byte - CHAR_ZERO;
   assign digit     = digit_raw[3:0];
   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign pos_next  = pos_ff + POS_W'(1);

   // digit times weight as a shift-add over four digit bits
   always_comb begin
      product = '0;
      for (int i = 0; i < 4; i++) begin
         if (digit[i]) begin
            product = product + ((WEIGHT_W+4)'(weight_ff) << i);
         end
      end
   end

   always_comb begin
      in_payload_in = in_payload_ff;
      pos_in        = pos_ff;
      opcode_in     = opcode_ff;
      length_in     = length_ff;
      weight_in     = weight_ff;
      ended_in      = ended_ff;
      remaining_in  = remaining_ff;
      push          = 1'b0;
      push_item     = '0;
      sum           = '0;
      if (accept) begin
         if (in_payload_ff) begin
            push                    = 1'b1;
            push_item.opcode_chars  = opcode_ff;
            push_item.frame_length  = length_ff;
            push_item.payload_valid = 1'b1;
            push_item.payload_byte  = rx_byte;
            if (remaining_ff <= LEN_W'(1)) begin
               push_item.last_of_frame = 1'b1;
               remaining_in            = '0;
               in_payload_in           = 1'b0;
               pos_in                  = '0;
               weight_in               = WEIGHT_W'(1);
               ended_in                = 1'b0;
            end else begin
               remaining_in = remaining_ff - LEN_W'(1);
            end
         end else begin
            if (pos_ff == '0) begin
               opcode_in = '0;
               length_in = '0;
            end
            if (pos_ff < POS_W'(OPCODE_CHARS)) begin
               opcode_in = {opcode_in[OPC_W-BYTE_W-1:0], rx_byte};
            end else if (!ended_ff) begin
               if (is_digit) begin
                  sum = (WEIGHT_W+5)'(length_in) + (WEIGHT_W+5)'(product);
                  if (sum > (WEIGHT_W+5)'(LEN_MAX)) begin
                     length_in = LEN_MAX;
                  end else begin
                     length_in = sum[LEN_W-1:0];
                  end
                  if (weight_ff <= WEIGHT_W'(LEN_MAX)) begin
                     weight_in = (weight_ff << 3) + (weight_ff << 1);
                  end
               end else begin
                  ended_in = 1'b1;
               end
            end
            pos_in = pos_next;
            if (pos_next == POS_W'(HDR_BYTES)) begin
               push                    = 1'b1;
               push_item.header_valid  = 1'b1;
               push_item.opcode_chars  = opcode_in;
               push_item.frame_length  = length_in;
               push_item.last_of_frame = (length_in == '0);
               pos_in                  = '0;
               weight_in               = WEIGHT_W'(1);
               ended_in                = 1'b0;
               if (length_in != '0) begin
                  in_payload_in = 1'b1;
                  remaining_in  = length_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         pos_ff        <= '0;
         weight_ff     <= WEIGHT_W'(1);
         ended_ff      <= 1'b0;
         remaining_ff  <= '0;
      end else begin
         in_payload_ff <= in_payload_in;
         pos_ff        <= pos_in;
         weight_ff     <= weight_in;
         ended_ff      <= ended_in;
         remaining_ff  <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      length_ff <= length_in;
   end

endmodule
`default_nettype wire

FILE: rtl/dld_queue.sv
// two-entry queue between front end and output stage
`default_nettype none
module dld_queue
   import dld_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire rsp_item_type push_item,
   input  wire logic   pop,
   output logic        full,
   output logic        empty,
   output rsp_item_type head_item
);

   rsp_item_type entries_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dld_back.sv
// output stage: registered result transaction
`default_nettype none
module dld_back
   import dld_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   empty,
   input  wire rsp_item_type head_item,
   output logic        pop,
   input  wire logic   rsp_stall,
   output logic        rsp_valid,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign pop = !empty && (!valid_ff || !rsp_stall);

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff && rsp_stall;
      if (pop) begin
         item_in  = head_item;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
`default_nettype wire

FILE: rtl/dld_checker.sv
// port checker for the decimal length deframer and its bind
`default_nettype none
module dld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_header_valid,
   input wire logic [33:0] rsp_frame_length,
   input wire logic        rsp_payload_valid,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic        rsp_last_of_frame
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_length)
         && $stable(rsp_payload_byte) && $stable(rsp_last_of_frame))
      else $error("rsp transaction changed while stalled");

   // every result is either a header or a payload byte
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_header_valid != rsp_payload_valid)
      else $error("rsp kind flags inconsistent");

   // header marks last exactly when the frame is empty and carries a zero payload byte
   a_hdr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_valid |->
         rsp_last_of_frame == (rsp_frame_length == 34'd0) && rsp_payload_byte == 8'd0)
      else $error("header last flag or byte wrong");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind decimal_length_deframer_top dld_checker u_dld_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_header_valid  (rsp_header_valid),
   .rsp_frame_length  (rsp_frame_length),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_last_of_frame (rsp_last_of_frame)
);
`default_nettype wire
